// ===== rtl/mwa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwa_pkg
// shared types and constants of the masked weighted accumulator: entry
// word layout, opcodes, result and clear-sequencer status records
// ----------------------------------------------------------------------------
package mwa_pkg;

	localparam int ENTRIES  = 4096;
	localparam int ENTRY_AW = $clog2(ENTRIES);

	localparam int POS_W    = 12;
	localparam int VALUE_W  = 16;
	localparam int WEIGHT_W = 10;
	localparam int SUM_W    = 48;
	localparam int COUNT_W  = 32;
	localparam int PROD_W   = VALUE_W + WEIGHT_W + 1;

	localparam int S_TDATA_W = 40;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 80;
	localparam int M_TUSER_W = 1;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [COUNT_W-1:0]      COUNT_MAX = {COUNT_W{1'b1}};

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ACC   = 2'd1,
		OP_READ  = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// one stored entry; valid lives in the same word as the data
	typedef struct packed {
		logic                     valid;
		logic [COUNT_W-1:0]       count;
		logic signed [SUM_W-1:0]  sum;
	} entry_t;

	typedef struct packed {
		logic signed [SUM_W-1:0]  sum;
		logic [COUNT_W-1:0]       count;
		logic                     sat;
	} result_t;

	typedef struct packed {
		logic                busy;
		logic [ENTRY_AW-1:0] addr;
	} sweep_t;

endpackage
`default_nettype wire

// ===== rtl/mwa_entry_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwa_entry_ram
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module mwa_entry_ram (
	input  wire logic                     clk,
	input  wire logic                     re,
	input  wire logic [mwa_pkg::ENTRY_AW-1:0] raddr,
	output mwa_pkg::entry_t               rdata,
	input  wire logic                     we,
	input  wire logic [mwa_pkg::ENTRY_AW-1:0] waddr,
	input  wire mwa_pkg::entry_t          wdata
);
	import mwa_pkg::*;

	entry_t mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/mwa_clear_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwa_clear_seq
// invalidation sweep over every entry, after reset and after each clear
// ----------------------------------------------------------------------------
module mwa_clear_seq (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	output mwa_pkg::sweep_t sweep
);
	import mwa_pkg::*;

	localparam logic [ENTRY_AW-1:0] LAST = ENTRY_AW'(ENTRIES - 1);

	logic                busy_q;
	logic [ENTRY_AW-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end else if (busy_q) begin
			if (addr_q == LAST) begin
				busy_q <= 1'b0;
				addr_q <= '0;
			end else begin
				addr_q <= addr_q + 1'b1;
			end
		end else if (start) begin
			busy_q <= 1'b1;
			addr_q <= '0;
		end
	end

	assign sweep.busy = busy_q;
	assign sweep.addr = addr_q;

endmodule
`default_nettype wire

// ===== rtl/mwa_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwa_update
// modify step: picks forwarded or stored entry, adds, saturates, and
// forms the write-back word and the reported result
// ----------------------------------------------------------------------------
module mwa_update (
	input  wire logic                         fire,
	input  wire mwa_pkg::op_t                 op,
	input  wire logic                         present,
	input  wire logic                         in_range,
	input  wire logic signed [mwa_pkg::PROD_W-1:0] prod,
	input  wire logic [mwa_pkg::WEIGHT_W-1:0] incr,
	input  wire mwa_pkg::entry_t              rd_word,
	input  wire logic                         fwd_hit,
	input  wire mwa_pkg::entry_t              fwd_word,
	output logic                              we,
	output mwa_pkg::entry_t                   wr_word,
	output mwa_pkg::result_t                  res
);
	import mwa_pkg::*;

	entry_t                  cur;
	logic signed [SUM_W-1:0] base_sum;
	logic [COUNT_W-1:0]      base_cnt;
	logic signed [SUM_W:0]   sum_wide;
	logic [COUNT_W:0]        cnt_wide;
	logic signed [SUM_W-1:0] sum_new;
	logic [COUNT_W-1:0]      cnt_new;
	logic                    sat_new;
	logic                    do_acc;

	always_comb begin
		cur      = fwd_hit ? fwd_word : rd_word;
		base_sum = cur.valid ? cur.sum : '0;
		base_cnt = cur.valid ? cur.count : '0;

		sum_wide = (SUM_W+1)'(base_sum) + (SUM_W+1)'(prod);
		cnt_wide = {1'b0, base_cnt} + (COUNT_W+1)'(incr);

		sat_new = 1'b0;
		if (sum_wide[SUM_W:SUM_W-1] == 2'b01) begin
			sum_new = SUM_MAX;
			sat_new = 1'b1;
		end else if (sum_wide[SUM_W:SUM_W-1] == 2'b10) begin
			sum_new = SUM_MIN;
			sat_new = 1'b1;
		end else begin
			sum_new = sum_wide[SUM_W-1:0];
		end
		if (cnt_wide[COUNT_W]) begin
			cnt_new = COUNT_MAX;
			sat_new = 1'b1;
		end else begin
			cnt_new = cnt_wide[COUNT_W-1:0];
		end

		do_acc = (op == OP_ACC) && present && in_range;

		wr_word.valid = 1'b1;
		wr_word.count = cnt_new;
		wr_word.sum   = sum_new;
		we            = fire && do_acc;

		res = '0;
		case (op)
			OP_ACC, OP_READ: begin
				if (in_range) begin
					if (do_acc) begin
						res.sum   = sum_new;
						res.count = cnt_new;
						res.sat   = sat_new;
					end else begin
						res.sum   = base_sum;
						res.count = base_cnt;
					end
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/masked_weighted_accumulator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// masked_weighted_accumulator
// aggregation store of per-position sums and counts with clear,
// accumulate and read commands, weighted or plain accumulation
// ----------------------------------------------------------------------------
//
// channel    dir  transfer contents
// s_axis     in   command: opcode, position, present flag, value, weight
// m_axis     out  one result per command: sum, count, saturated flag
// cfg        in   weighted_mode register write, no read-back
//
// - one command per cycle while s_axis_tready is high; result registered after the read stage
// - the entry store is one memory with a registered read; a write-back in
//   the cycle of the next read to the same entry is forwarded
// - reset and every clear run an invalidation sweep over all ENTRIES
//   (4096) entries, s_axis_tready low throughout
// - the result register lets a new command in while a result waits; a
//   stalled m_axis backs up into s_axis_tready
//
module masked_weighted_accumulator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_wdata,  // weighted_mode
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// position[11:0], value[27:12], weight[37:28], zero fill
	input  wire logic [mwa_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// opcode[1:0], present[2]
	input  wire logic [mwa_pkg::S_TUSER_W-1:0]  s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	// sum[47:0], count[79:48]
	output logic [mwa_pkg::M_TDATA_W-1:0]       m_axis_tdata,
	// saturated[0]
	output logic [mwa_pkg::M_TUSER_W-1:0]       m_axis_tuser
);
	import mwa_pkg::*;

	// configuration
	logic weighted_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weighted_mode_q <= 1'b0;
		end else if (cfg_we) begin
			weighted_mode_q <= cfg_wdata;
		end
	end

	// input field unpack
	op_t                        in_op;
	logic                       in_present;
	logic [POS_W-1:0]           in_pos;
	logic signed [VALUE_W-1:0]  in_value;
	logic [WEIGHT_W-1:0]        in_weight;
	logic [ENTRY_AW-1:0]        in_addr;
	logic                       in_range;
	logic signed [PROD_W-1:0]   in_prod;
	logic [WEIGHT_W-1:0]        in_incr;

	assign in_op      = op_t'(s_axis_tuser[1:0]);
	assign in_present = s_axis_tuser[2];
	assign in_pos     = s_axis_tdata[11:0];
	assign in_value   = s_axis_tdata[27:12];
	assign in_weight  = s_axis_tdata[37:28];
	assign in_addr    = ENTRY_AW'(in_pos);
	assign in_range   = (int'(in_pos) < ENTRIES);

	// scaling done ahead of the memory read so the add stage sees no multiply
	always_comb begin
		if (weighted_mode_q) begin
			in_prod = PROD_W'(in_value) * PROD_W'($signed({1'b0, in_weight}));
			in_incr = in_weight;
		end else begin
			in_prod = PROD_W'(in_value);
			in_incr = WEIGHT_W'(1);
		end
	end

	// handshake
	sweep_t sweep;
	logic   valid_s1;
	logic   out_valid_q;
	logic   adv;
	logic   in_xfer;

	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !sweep.busy && (!valid_s1 || adv);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	// stage 1: memory read in flight
	op_t                      op_s1;
	logic                     present_s1;
	logic                     in_range_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic [WEIGHT_W-1:0]      incr_s1;
	logic [ENTRY_AW-1:0]      addr_s1;
	logic                     hit_s1;
	entry_t                   fwd_s1;

	entry_t  rd_word;
	logic    upd_we;
	entry_t  upd_word;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1       <= in_op;
			present_s1  <= in_present;
			in_range_s1 <= in_range;
			prod_s1     <= in_prod;
			incr_s1     <= in_incr;
			addr_s1     <= in_addr;
			// write-back landing on this edge is not in the read data
			hit_s1      <= upd_we && (addr_s1 == in_addr);
			fwd_s1      <= upd_word;
		end
	end

	// modify and write back
	mwa_update u_update (
		.fire     (valid_s1 && adv),
		.op       (op_s1),
		.present  (present_s1),
		.in_range (in_range_s1),
		.prod     (prod_s1),
		.incr     (incr_s1),
		.rd_word  (rd_word),
		.fwd_hit  (hit_s1),
		.fwd_word (fwd_s1),
		.we       (upd_we),
		.wr_word  (upd_word),
		.res      (res)
	);

	// clear sequencer; never writes in a cycle with an update write
	mwa_clear_seq u_clear (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_xfer && (in_op == OP_CLEAR)),
		.sweep  (sweep)
	);

	logic                wr_en;
	logic [ENTRY_AW-1:0] wr_addr;
	entry_t              wr_word;

	assign wr_en   = sweep.busy || upd_we;
	assign wr_addr = sweep.busy ? sweep.addr : addr_s1;
	assign wr_word = sweep.busy ? entry_t'('0) : upd_word;

	mwa_entry_ram u_ram (
		.clk   (clk),
		.re    (in_xfer && in_range),
		.raddr (in_addr),
		.rdata (rd_word),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_word)
	);

	// result register
	logic signed [SUM_W-1:0] out_sum_q;
	logic [COUNT_W-1:0]      out_count_q;
	logic                    out_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			out_sum_q   <= res.sum;
			out_count_q <= res.count;
			out_sat_q   <= res.sat;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_count_q, out_sum_q};
	assign m_axis_tuser  = out_sat_q;

endmodule
`default_nettype wire

// ===== rtl/mwa_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mwa_checker
// port-level checks of the masked weighted accumulator, bound to the top
// ----------------------------------------------------------------------------
module mwa_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,
	input  wire logic [2:0]  s_axis_tuser,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [79:0] m_axis_tdata,
	input  wire logic [0:0]  m_axis_tuser
);
	import mwa_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a clear transfer starts the sweep, which blocks commands
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser[1:0] == OP_CLEAR)
		|=> !s_axis_tready)
		else $error("command taken during clear sweep");

	// saturation only reported with a clipped value
	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
		(m_axis_tdata[47:0] == SUM_MAX) || (m_axis_tdata[47:0] == SUM_MIN) ||
		(m_axis_tdata[79:48] == COUNT_MAX))
		else $error("saturated flag without limit value");

	// no result and no command ready while in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid && !s_axis_tready)
		else $error("handshake active in reset");

endmodule

bind masked_weighted_accumulator mwa_checker u_mwa_checker (.*);
`default_nettype wire

// ===== verif/tb_masked_weighted_accumulator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_masked_weighted_accumulator
// self-checking bench for the masked weighted accumulator: commands stream
// in through s_axis under bursty valid, results are checked one by one
// against a local copy of the entry store, m_axis stalls on its own pattern
// ----------------------------------------------------------------------------
module tb_masked_weighted_accumulator;

	timeunit 1ns;
	timeprecision 1ps;

	import mwa_pkg::*;

	// saturation bounds of the stored entry, held wide for the arithmetic
	localparam longint SUM_TOP    = 64'sd140737488355327;
	localparam longint SUM_BOTTOM = -SUM_TOP - 64'sd1;
	localparam longint COUNT_TOP  = 64'sd4294967295;

	// one command as it travels on s_axis
	typedef struct packed {
		op_t                        op;
		logic [POS_W-1:0]           pos;
		logic                       present;
		logic signed [VALUE_W-1:0]  value;
		logic [WEIGHT_W-1:0]        weight;
	} cmd_t;

	// how m_axis_tready behaves in the current stretch
	typedef enum int {
		RX_FREE,     // always ready
		RX_COIN,     // ready half the time at random
		RX_QUARTER,  // ready one cycle in four
		RX_MOSTLY    // ready seven eighths of the time at random
	} rx_pattern_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b1;
	logic                   cfg_we = 1'b0;
	logic                   cfg_wdata = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [S_TDATA_W-1:0]   s_axis_tdata = '0;
	logic [S_TUSER_W-1:0]   s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_axis_tdata;
	logic [M_TUSER_W-1:0]   m_axis_tuser;

	masked_weighted_accumulator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// local copy of the entry store and the mode register
	longint   tally_sum   [ENTRIES];
	longint   tally_count [ENTRIES];
	bit       tally_valid [ENTRIES];
	bit       weighted = 1'b0;

	cmd_t     cmd_queue[$];        // commands not yet offered on s_axis
	result_t  pending_results[$];  // predicted results, oldest first
	int       errors = 0;

	// sender burst state
	cmd_t     cur_cmd;
	int       burst_left = 8;
	int       gap_left = 0;

	// receiver stall state
	rx_pattern_t rx_mode = RX_FREE;
	int       rx_left = 0;
	int       rx_phase = 0;
	int       hold_left = 0;
	bit       hold_req = 1'b0;
	bit       hold_done = 1'b0;
	bit       rx_ready;

	// actual result fields, unpacked from m_axis
	logic signed [SUM_W-1:0] got_sum;
	logic [COUNT_W-1:0]      got_count;
	logic                    got_sat;
	result_t                 want;

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// predictor: applies one command to the local store, returns the result
	// ------------------------------------------------------------------
	function automatic result_t apply_command(input cmd_t c);
		result_t r;
		longint  s;
		longint  n;
		bit      clipped;
		int      idx;
		r = '0;
		clipped = 1'b0;
		idx = int'(c.pos);
		if (c.op == OP_CLEAR) begin
			// clear drops every valid bit, the result is all zero
			foreach (tally_valid[i]) tally_valid[i] = 1'b0;
			return r;
		end
		if (c.op == OP_NOP || idx >= ENTRIES) begin
			return r;
		end
		// an invalid entry acts as zero
		s = tally_valid[idx] ? tally_sum[idx] : 64'sd0;
		n = tally_valid[idx] ? tally_count[idx] : 64'sd0;
		if (c.op == OP_ACC && c.present) begin
			if (weighted) begin
				s = s + longint'(c.value) * longint'(c.weight);
				n = n + longint'(c.weight);
			end else begin
				s = s + longint'(c.value);
				n = n + 64'sd1;
			end
			if (s > SUM_TOP) begin
				s = SUM_TOP;
				clipped = 1'b1;
			end
			if (s < SUM_BOTTOM) begin
				s = SUM_BOTTOM;
				clipped = 1'b1;
			end
			if (n > COUNT_TOP) begin
				n = COUNT_TOP;
				clipped = 1'b1;
			end
			tally_sum[idx]   = s;
			tally_count[idx] = n;
			tally_valid[idx] = 1'b1;
		end
		r.sum   = s[SUM_W-1:0];
		r.count = n[COUNT_W-1:0];
		r.sat   = clipped;
		return r;
	endfunction

	function automatic cmd_t mk(input op_t op, input logic [POS_W-1:0] pos,
			input logic present, input logic signed [VALUE_W-1:0] value,
			input logic [WEIGHT_W-1:0] weight);
		cmd_t c;
		c.op      = op;
		c.pos     = pos;
		c.present = present;
		c.value   = value;
		c.weight  = weight;
		return c;
	endfunction

	// random command; most positions land in a small pool so entries are
	// hit many times, the rest anywhere in the store
	function automatic cmd_t random_cmd(input int base);
		cmd_t c;
		int   roll;
		roll = $urandom_range(0, 99);
		if (roll < 1)
			c.op = OP_CLEAR;
		else if (roll < 4)
			c.op = OP_NOP;
		else if (roll < 22)
			c.op = OP_READ;
		else
			c.op = OP_ACC;
		if ($urandom_range(0, 9) < 6)
			c.pos = POS_W'(base + $urandom_range(0, 15));
		else
			c.pos = POS_W'($urandom());
		c.present = ($urandom_range(0, 99) < 85);
		case ($urandom_range(0, 9))
			0: c.value = 16'sh7fff;
			1: c.value = 16'sh8000;
			default: c.value = VALUE_W'($urandom());
		endcase
		case ($urandom_range(0, 9))
			0: c.weight = '0;
			1: c.weight = 10'd999;
			2: c.weight = WEIGHT_W'($urandom_range(1000, 1023));
			default: c.weight = WEIGHT_W'($urandom_range(0, 999));
		endcase
		return c;
	endfunction

	// fill the queue with one phase of random traffic, with runs of
	// accumulates on one position to exercise write-back forwarding
	task automatic fill_random(input int n);
		int   base;
		int   made;
		int   run;
		cmd_t c;
		base = $urandom_range(0, ENTRIES - 16);
		made = 0;
		while (made < n) begin
			c = random_cmd(base);
			if (c.op == OP_ACC && $urandom_range(0, 9) == 0) begin
				run = $urandom_range(2, 6);
				repeat (run) begin
					c.value   = VALUE_W'($urandom());
					c.present = ($urandom_range(0, 7) != 0);
					cmd_queue.push_back(c);
				end
				made += run;
			end else begin
				cmd_queue.push_back(c);
				made++;
			end
		end
	endtask

	// sender paused: wait until everything offered has come back and any
	// invalidation sweep is over
	task automatic wait_idle();
		do @(negedge clk);
		while (cmd_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0
			|| !s_axis_tready);
	endtask

	// mode register write, only while the block is idle
	task automatic set_mode(input bit m);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		weighted  = m;
	endtask

	// ------------------------------------------------------------------
	// driver: offers queued commands in bursts, predicts on each transfer
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				pending_results.push_back(apply_command(cur_cmd));
			end
			if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (cmd_queue.size() != 0) begin
				cur_cmd = cmd_queue.pop_front();
				// position, value, weight from bit 0 up, zero fill
				s_axis_tdata  <= {2'b00, cur_cmd.weight, cur_cmd.value, cur_cmd.pos};
				// opcode, present
				s_axis_tuser  <= {cur_cmd.present, cur_cmd.op};
				s_axis_tvalid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					// some bursts run straight into the next one
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: checks each result transfer, drives the receiver stalls
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			got_sum   = m_axis_tdata[SUM_W-1:0];
			got_count = m_axis_tdata[SUM_W+COUNT_W-1:SUM_W];
			got_sat   = m_axis_tuser[0];
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: sum %0d count %0d saturated %0b",
					got_sum, got_count, got_sat);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got_sum !== want.sum) begin
					$error("sum: expected %0d, actual %0d", $signed(want.sum), got_sum);
					errors++;
				end
				if (got_count !== want.count) begin
					$error("count: expected %0d, actual %0d", want.count, got_count);
					errors++;
				end
				if (got_sat !== want.sat) begin
					$error("saturated: expected %0b, actual %0b", want.sat, got_sat);
					errors++;
				end
			end
		end

		// long hold-off, once, so the block fills and backs up s_axis
		if (hold_req && !hold_done) begin
			hold_left = 600;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			rx_ready = 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_pattern_t'($urandom_range(0, 3));
				rx_left = $urandom_range(16, 200);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_FREE:    rx_ready = 1'b1;
				RX_COIN:    rx_ready = 1'($urandom_range(0, 1));
				RX_QUARTER: rx_ready = (rx_phase % 4 == 0);
				default:    rx_ready = ($urandom_range(0, 7) != 0);
			endcase
			rx_phase++;
		end
		m_axis_tready <= rx_ready;
	end

	// ------------------------------------------------------------------
	// stimulus: directed commands in both modes, then random phases
	// ------------------------------------------------------------------
	initial begin
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		// plain mode: extremes, invalid reads, absent values, nop, clear
		set_mode(1'b0);
		cmd_queue.push_back(mk(OP_READ,  12'd0,    1'b0, 16'sd0,      10'd0));
		cmd_queue.push_back(mk(OP_READ,  12'd4095, 1'b1, -16'sd1,     10'd1023));
		cmd_queue.push_back(mk(OP_ACC,   12'd0,    1'b1, 16'sd32767,  10'd999));
		cmd_queue.push_back(mk(OP_ACC,   12'd0,    1'b1, -16'sd32768, 10'd0));
		cmd_queue.push_back(mk(OP_ACC,   12'd0,    1'b1, -16'sd32768, 10'd1023));
		cmd_queue.push_back(mk(OP_ACC,   12'd0,    1'b0, 16'sd12345,  10'd5));
		cmd_queue.push_back(mk(OP_READ,  12'd0,    1'b0, 16'sd0,      10'd0));
		cmd_queue.push_back(mk(OP_ACC,   12'd4095, 1'b1, -16'sd32768, 10'd1));
		cmd_queue.push_back(mk(OP_ACC,   12'd4095, 1'b1, -16'sd32768, 10'd1));
		cmd_queue.push_back(mk(OP_NOP,   12'd4095, 1'b1, 16'sd32767,  10'd1023));
		cmd_queue.push_back(mk(OP_READ,  12'd4095, 1'b0, 16'sd0,      10'd0));
		cmd_queue.push_back(mk(OP_CLEAR, 12'd0,    1'b0, 16'sd0,      10'd0));
		cmd_queue.push_back(mk(OP_READ,  12'd0,    1'b0, 16'sd0,      10'd0));
		cmd_queue.push_back(mk(OP_READ,  12'd4095, 1'b0, 16'sd0,      10'd0));
		// absent value on a cleared entry reads as zero
		cmd_queue.push_back(mk(OP_ACC,   12'd4095, 1'b0, 16'sd99,     10'd9));
		cmd_queue.push_back(mk(OP_ACC,   12'd4095, 1'b1, 16'sd7,      10'd3));
		wait_idle();

		// weighted mode: zero weight still validates, weights past 999
		set_mode(1'b1);
		cmd_queue.push_back(mk(OP_ACC,   12'd5,    1'b1, 16'sd32767,  10'd0));
		cmd_queue.push_back(mk(OP_READ,  12'd5,    1'b0, 16'sd0,      10'd0));
		cmd_queue.push_back(mk(OP_ACC,   12'd5,    1'b1, 16'sd32767,  10'd999));
		cmd_queue.push_back(mk(OP_ACC,   12'd5,    1'b1, -16'sd32768, 10'd1023));
		cmd_queue.push_back(mk(OP_ACC,   12'd5,    1'b1, -16'sd32768, 10'd1023));
		cmd_queue.push_back(mk(OP_ACC,   12'd5,    1'b0, 16'sd100,    10'd100));
		cmd_queue.push_back(mk(OP_ACC,   12'd4095, 1'b1, 16'sd32767,  10'd1023));
		cmd_queue.push_back(mk(OP_CLEAR, 12'd4095, 1'b1, -16'sd1,     10'd1023));
		cmd_queue.push_back(mk(OP_READ,  12'd5,    1'b0, 16'sd0,      10'd0));
		wait_idle();

		// random phases, alternating the mode
		for (int ph = 0; ph < 5; ph++) begin
			set_mode(ph % 2 == 0);
			fill_random(225);
			if (ph == 0) hold_req = 1'b1;
			wait_idle();
		end

		// drain margin for anything the block should not still send
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("tb_masked_weighted_accumulator: done, clean");
		end else begin
			$display("tb_masked_weighted_accumulator: done, errors");
		end
		$finish;
	end

	// watchdog, far beyond the slowest correct run including every sweep
	initial begin
		#2_000_000;
		$display("tb_masked_weighted_accumulator: done, errors");
		$finish;
	end

endmodule
`default_nettype wire
